/* rtl/kc_pkg.sv */
// Package for the keyword classifier: keyword spelling table, lengths,
// token kind codes and the per-lexeme state type. No dependencies.
package kc_pkg;

  localparam int WORD_COUNT = 14;
  localparam int WORD_MAX   = 8;
  localparam int POS_W      = 4;
  localparam int KIND_W     = 4;
  localparam int CHAR_W     = 8;

  localparam logic [POS_W-1:0]      POS_MAX  = 4'd15;
  localparam logic [WORD_COUNT-1:0] MASK_ALL = {WORD_COUNT{1'b1}};

  // Token kinds
  localparam logic [KIND_W-1:0] KIND_IDENT    = 4'd0;
  localparam logic [KIND_W-1:0] KIND_BREAK    = 4'd1;
  localparam logic [KIND_W-1:0] KIND_CLASS    = 4'd2;
  localparam logic [KIND_W-1:0] KIND_CONTINUE = 4'd3;
  localparam logic [KIND_W-1:0] KIND_ELSE     = 4'd4;
  localparam logic [KIND_W-1:0] KIND_FALSE    = 4'd5;
  localparam logic [KIND_W-1:0] KIND_FOR      = 4'd6;
  localparam logic [KIND_W-1:0] KIND_FN       = 4'd7;
  localparam logic [KIND_W-1:0] KIND_IF       = 4'd8;
  localparam logic [KIND_W-1:0] KIND_LET      = 4'd9;
  localparam logic [KIND_W-1:0] KIND_NULL     = 4'd10;
  localparam logic [KIND_W-1:0] KIND_PRINT    = 4'd11;
  localparam logic [KIND_W-1:0] KIND_RETURN   = 4'd12;
  localparam logic [KIND_W-1:0] KIND_TRUE     = 4'd13;
  localparam logic [KIND_W-1:0] KIND_WHILE    = 4'd14;

  // Keyword spelling, one row per keyword (row k is kind k+1), zero padded.
  localparam logic [CHAR_W-1:0] WORD_CHAR [WORD_COUNT][WORD_MAX] = '{
    '{"b", "r", "e", "a", "k", 8'h00, 8'h00, 8'h00},
    '{"c", "l", "a", "s", "s", 8'h00, 8'h00, 8'h00},
    '{"c", "o", "n", "t", "i", "n", "u", "e"},
    '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"f", "a", "l", "s", "e", 8'h00, 8'h00, 8'h00},
    '{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"f", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"l", "e", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"n", "u", "l", "l", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"p", "r", "i", "n", "t", 8'h00, 8'h00, 8'h00},
    '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
    '{"t", "r", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00}
  };

  localparam logic [POS_W-1:0] WORD_LEN [WORD_COUNT] = '{
    4'd5, 4'd5, 4'd8, 4'd4, 4'd5, 4'd3, 4'd2, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd4, 4'd5
  };

  typedef struct packed {
    logic [WORD_COUNT-1:0] mask;
    logic [POS_W-1:0]      pos;
  } kc_state_t;

endpackage

/* rtl/keyword_classifier.sv */
// Keyword classifier top level: stream ports, lexeme state and result register.
// Depends on kc_pkg and kc_match.
//
// Usage
//   Slave side carries one lexeme character per transfer: s_tdata is the
//   character byte, s_tlast flags the final character of the lexeme.
//   Master side carries one transfer per lexeme, issued for the final
//   character: m_tdata[3:0] is the token kind (0 identifier, 1..14 the
//   keywords break..while), upper bits zero.
//   The result is registered on m_tdata in the cycle after the final
//   character's transfer. Throughput: one character per cycle while s_tready
//   is high, set by the single register stage for the candidate mask and
//   position; mask update and kind select are one level of 14 parallel compares.
//   The result register is the only buffer toward the receiver: while it
//   holds an untaken result and m_tready is low, s_tready drops. When it is
//   taken in the same cycle a new character may be accepted.
//   Reset (rst, synchronous, active high) sets all keywords as candidates,
//   the position to zero and drops m_tvalid. After each final character the
//   state returns to that same value, ready for the next lexeme.
//   The position saturates at 15, past the longest keyword, so overlong
//   lexemes classify as identifiers.
module keyword_classifier (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] symbol_char
  input  logic       s_tlast,   // lexeme_last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [3:0] token_kind, [7:4] zero
);
  import kc_pkg::*;

  kc_state_t             state;
  logic [WORD_COUNT-1:0] mask_next;
  logic [KIND_W-1:0]     kind_next;
  logic                  in_xfer;
  logic                  out_xfer;

  kc_match u_match (
    .state      (state),
    .symbol_char(s_tdata),
    .mask_next  (mask_next),
    .token_kind (kind_next)
  );

  // Room for a new character whenever the result register is empty or draining
  assign s_tready = !m_tvalid || m_tready;
  assign in_xfer  = s_tvalid && s_tready;
  assign out_xfer = m_tvalid && m_tready;

  // Lexeme state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mask <= MASK_ALL;
      state.pos  <= '0;
    end else if (in_xfer) begin
      if (s_tlast) begin
        state.mask <= MASK_ALL;
        state.pos  <= '0;
      end else begin
        state.mask <= mask_next;
        state.pos  <= (state.pos == POS_MAX) ? POS_MAX : state.pos + 4'd1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_xfer && s_tlast) begin
      m_tvalid <= 1'b1;
    end else if (out_xfer) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && s_tlast) begin
      m_tdata <= {4'd0, kind_next};
    end
  end

  // Checks
  a_restart: assert property (@(posedge clk) disable iff (rst)
    in_xfer && s_tlast |=> state.pos == '0 && state.mask == MASK_ALL)
    else $error("lexeme state not restored after final character");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    in_xfer && !s_tlast && state.pos != POS_MAX |=> state.pos == $past(state.pos) + 4'd1)
    else $error("position did not advance");

  a_mask_shrinks: assert property (@(posedge clk) disable iff (rst)
    in_xfer && !s_tlast |=> (state.mask & ~$past(state.mask)) == '0)
    else $error("candidate mask gained a bit mid-lexeme");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:4] == 4'd0 && m_tdata[3:0] <= KIND_WHILE)
    else $error("token kind out of range");

  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(in_xfer && s_tlast))
    else $error("result without final character");

endmodule

/* rtl/kc_match.sv */
// Keyword match logic: narrows the candidate mask by one character and
// picks the token kind for a lexeme ending here. Uses kc_pkg.
module kc_match (
  input  kc_pkg::kc_state_t             state,
  input  logic [kc_pkg::CHAR_W-1:0]     symbol_char,
  output logic [kc_pkg::WORD_COUNT-1:0] mask_next,
  output logic [kc_pkg::KIND_W-1:0]     token_kind
);
  import kc_pkg::*;

  // One independent compare per keyword
  always_comb begin
    for (int k = 0; k < WORD_COUNT; k++) begin
      mask_next[k] = state.mask[k] && (state.pos < WORD_LEN[k]) &&
                     (WORD_CHAR[k][state.pos[2:0]] == symbol_char);
    end
  end

  // Exact length match; at most one keyword can hit, lowest index wins anyway
  always_comb begin
    token_kind = KIND_IDENT;
    for (int k = WORD_COUNT - 1; k >= 0; k--) begin
      if (mask_next[k] &&
          (({1'b0, state.pos} + 5'd1) == {1'b0, WORD_LEN[k]})) begin
        token_kind = KIND_W'(k + 1);
      end
    end
  end

endmodule

/* tb/sv/tb_keyword_classifier.sv */
// Self-checking testbench for keyword_classifier: streams lexemes one character
// per transfer and checks every token kind against a mask/position predictor.
// Depends on kc_pkg and the keyword_classifier RTL.
module tb_keyword_classifier;
  timeunit 1ns;
  timeprecision 1ps;

  import kc_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;  // far above the slowest legal run
  localparam int DRAIN_LIMIT  = 1000;    // cycles allowed for the last results
  localparam int TAIL_CYCLES  = 8;       // settling cycles after the last result
  localparam int PHASE_CHARS  = 130;     // random characters per idling phase

  typedef logic [CHAR_W-1:0] char_q_t [$];

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT
  // ---------------------------------------------------------------------------
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [CHAR_W-1:0] s_tdata = '0;    // [7:0] symbol_char
  logic              s_tlast = 1'b0;  // lexeme_last
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [7:0]        m_tdata;         // [3:0] token_kind, [7:4] zero

  initial begin
    forever #2 clk = ~clk;
  end

  keyword_classifier dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // ---------------------------------------------------------------------------
  // Keyword table, kept independent of the package spelling table so that a
  // typo there shows up as a mismatch. Entry k maps to kind kw_kind[k].
  // ---------------------------------------------------------------------------
  string kw_spelling [WORD_COUNT] = '{
    "break", "class", "continue", "else", "false", "for", "fn",
    "if", "let", "null", "print", "return", "true", "while"
  };

  logic [KIND_W-1:0] kw_kind [WORD_COUNT] = '{
    KIND_BREAK, KIND_CLASS, KIND_CONTINUE, KIND_ELSE, KIND_FALSE, KIND_FOR,
    KIND_FN, KIND_IF, KIND_LET, KIND_NULL, KIND_PRINT, KIND_RETURN,
    KIND_TRUE, KIND_WHILE
  };

  // ---------------------------------------------------------------------------
  // Predictor state: keywords still matching and index of the next character.
  // ---------------------------------------------------------------------------
  logic [WORD_COUNT-1:0] live_words = MASK_ALL;
  logic [POS_W-1:0]      char_idx   = '0;
  logic [KIND_W-1:0]     expected_kinds [$];
  int                    mismatch_count = 0;

  // Idle rates in percent, changed per phase by the main sequence.
  int send_idle_pct = 38;
  int recv_idle_pct = 62;

  // Advance the lexeme state by one accepted character. On the final one,
  // pick the first keyword that survived every compare and whose length is
  // exactly the lexeme length, queue its kind, and start over.
  task automatic classify_char(input logic [CHAR_W-1:0] ch, input logic is_last);
    logic [WORD_COUNT-1:0] still;
    logic [KIND_W-1:0]     kind;
    bit                    found;
    still = live_words;
    for (int k = 0; k < WORD_COUNT; k++) begin
      if (int'(char_idx) >= kw_spelling[k].len())
        still[k] = 1'b0;
      else if (kw_spelling[k][char_idx] != ch)
        still[k] = 1'b0;
    end
    if (is_last) begin
      kind  = KIND_IDENT;
      found = 1'b0;
      for (int k = 0; k < WORD_COUNT; k++) begin
        if (!found && still[k] && int'(char_idx) + 1 == kw_spelling[k].len()) begin
          kind  = kw_kind[k];
          found = 1'b1;
        end
      end
      expected_kinds.push_back(kind);
      live_words = MASK_ALL;
      char_idx   = '0;
    end else begin
      live_words = still;
      // counter sticks at its top value; overlong lexemes end as identifiers
      char_idx   = (char_idx == POS_MAX) ? POS_MAX : char_idx + 1'b1;
    end
  endtask

  // Scoreboard: results are checked before the same-edge character is
  // predicted, so the oldest expectation is always the one on the bus.
  always @(posedge clk) begin
    logic [KIND_W-1:0] want;
    if (rst) begin
      live_words = MASK_ALL;
      char_idx   = '0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_kinds.size() == 0) begin
          $error("token_kind: unexpected result, expected none, actual %0d",
                 m_tdata[KIND_W-1:0]);
          mismatch_count++;
        end else begin
          want = expected_kinds.pop_front();
          if (m_tdata[KIND_W-1:0] !== want) begin
            $error("token_kind: expected %0d, actual %0d", want, m_tdata[KIND_W-1:0]);
            mismatch_count++;
          end
          if (m_tdata[7:KIND_W] !== '0) begin
            $error("tdata pad bits: expected 0, actual %0h", m_tdata[7:KIND_W]);
            mismatch_count++;
          end
        end
      end
      if (s_tvalid && s_tready)
        classify_char(s_tdata, s_tlast);
    end
  end

  // Receiver backpressure, redrawn every cycle.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog.
  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic char_q_t spell(input string w);
    char_q_t q;
    for (int i = 0; i < w.len(); i++)
      q.push_back(w[i]);
    return q;
  endfunction

  function automatic logic [CHAR_W-1:0] random_letter();
    return CHAR_W'("a" + $urandom_range(25));
  endfunction

  // One character transfer. Idle cycles drop tvalid and put noise on the
  // data lines; valid stays high across back-to-back transfers.
  task automatic send_char(input logic [CHAR_W-1:0] ch, input logic is_last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= CHAR_W'($urandom);
      s_tlast  <= 1'($urandom);
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tlast  <= is_last;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_lexeme(input char_q_t lex);
    for (int i = 0; i < lex.size(); i++)
      send_char(lex[i], i == lex.size() - 1);
  endtask

  // Mostly keyword-shaped lexemes (exact, truncated, extended, one byte off,
  // overlong), plus plain identifiers and arbitrary bytes.
  function automatic char_q_t random_lexeme();
    char_q_t lex;
    int      pick;
    int      n;
    pick = $urandom_range(99);
    lex  = spell(kw_spelling[$urandom_range(WORD_COUNT - 1)]);
    if (pick < 30) begin
      // exact keyword
    end else if (pick < 45) begin
      n = $urandom_range(lex.size() - 1, 1);
      while (lex.size() > n) void'(lex.pop_back());
    end else if (pick < 55) begin
      repeat ($urandom_range(3, 1)) lex.push_back(random_letter());
    end else if (pick < 65) begin
      n = $urandom_range(lex.size() - 1);
      lex[n] = CHAR_W'($urandom);
    end else if (pick < 72) begin
      // overlong: around the point where the position counter saturates
      n = $urandom_range(20, 14);
      while (lex.size() < n) lex.push_back(random_letter());
    end else if (pick < 85) begin
      lex.delete();
      repeat ($urandom_range(8, 1)) lex.push_back(random_letter());
    end else begin
      lex.delete();
      repeat ($urandom_range(6, 1)) lex.push_back(CHAR_W'($urandom));
    end
    return lex;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Single-character lexemes at both ends of the byte range.
  task automatic test_byte_extremes();
    char_q_t lex;
    lex = '{8'h00};
    send_lexeme(lex);
    lex = '{8'hFF};
    send_lexeme(lex);
  endtask

  // Two-letter keywords and a one-letter prefix of one of them.
  task automatic test_short_words();
    send_lexeme(spell("fn"));
    send_lexeme(spell("if"));
    send_lexeme(spell("f"));
  endtask

  // Sixteen characters: the counter sits at its top value on the last one.
  task automatic test_overlong_lexeme();
    send_lexeme(spell("continuecontinue"));
  endtask

  // Every keyword exactly, one character short, and one character long.
  task automatic test_keyword_sweep();
    char_q_t lex;
    for (int k = 0; k < WORD_COUNT; k++) begin
      lex = spell(kw_spelling[k]);
      send_lexeme(lex);
      void'(lex.pop_back());
      send_lexeme(lex);
      lex = spell(kw_spelling[k]);
      lex.push_back(random_letter());
      send_lexeme(lex);
    end
  endtask

  task automatic test_random_lexemes(input int char_budget);
    char_q_t lex;
    int      sent;
    sent = 0;
    while (sent < char_budget) begin
      lex = random_lexeme();
      send_lexeme(lex);
      sent += lex.size();
    end
  endtask

  // Stop sending, wait for outstanding results, then let the pipe settle.
  task automatic drain_results();
    int waited;
    @(negedge clk);
    s_tvalid <= 1'b0;
    waited = 0;
    while (expected_kinds.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_kinds.size() != 0) begin
      $error("token_kind: %0d expected results never arrived", expected_kinds.size());
      mismatch_count++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // phase 1: sender idles 38%, receiver 62%
    send_idle_pct = 38;
    recv_idle_pct = 62;
    test_byte_extremes();
    test_short_words();
    test_overlong_lexeme();
    test_keyword_sweep();
    test_random_lexemes(PHASE_CHARS);

    // phase 2: rates swapped
    send_idle_pct = 62;
    recv_idle_pct = 38;
    test_random_lexemes(PHASE_CHARS);

    // phase 3: full rate both ways
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_lexemes(PHASE_CHARS);

    drain_results();

    if (mismatch_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

/* keyword_classifier.f */
rtl/kc_pkg.sv
rtl/kc_match.sv
rtl/keyword_classifier.sv
tb/sv/tb_keyword_classifier.sv
